[hdl/grid_local_peak_finder_macros.svh]
// Assertion macros shared by the checker of the grid local peak finder
`ifndef GRID_LOCAL_PEAK_FINDER_MACROS_SVH
`define GRID_LOCAL_PEAK_FINDER_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define GLPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset
`define GLPF_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("%m: assertion failed");

`endif

[hdl/glpf_pkg.sv]
// Types, constants and defaults of the grid local peak finder
package glpf_pkg;

	localparam int MAX_COLS_DEF = 32;
	localparam int MAX_ROWS_DEF = 32;

	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 5;
	localparam int DIM_W    = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIM_W-1:0] DIM_RESET = 6'd20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC,
		ST_EMIT_UP,
		ST_SCAN
	} glpf_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic fetch;
		logic calc;
		logic emit_up;
		logic scan;
	} glpf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic first_col;
		logic pk_up;
		logic last_px;
		logic last_px_q;
		logic out_free;
		logic scan_adv;
		logic scan_last;
	} glpf_stat_t;

endpackage

[hdl/glpf_if.sv]
// Channel interfaces of the grid local peak finder

interface glpf_sample_if;
	logic valid;
	logic ready;
	logic signed [glpf_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface glpf_peak_if;
	logic valid;
	logic ready;
	logic [glpf_pkg::POS_W-1:0] peak_row;
	logic [glpf_pkg::POS_W-1:0] peak_col;
	logic frame_end;

	modport source (output valid, output peak_row, output peak_col, output frame_end,
		input ready);
	modport sink (input valid, input peak_row, input peak_col, input frame_end,
		output ready);
endinterface

interface glpf_cfg_if;
	logic valid;
	logic ready;
	logic [glpf_pkg::CFG_IDX_W-1:0] idx;
	logic [glpf_pkg::DIM_W-1:0] wdata;

	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

[hdl/glpf_ctrl.sv]
// Controller state machine of the grid local peak finder
module glpf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  glpf_pkg::glpf_stat_t stat,
	output glpf_pkg::glpf_cmd_t  cmd
);

	glpf_pkg::glpf_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			glpf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = stat.first_col ? glpf_pkg::ST_FETCH : glpf_pkg::ST_CALC;
				end
			end
			glpf_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = glpf_pkg::ST_CALC;
			end
			glpf_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				if (stat.pk_up) begin
					state_d = glpf_pkg::ST_EMIT_UP;
				end else if (stat.last_px) begin
					state_d = glpf_pkg::ST_SCAN;
				end else begin
					state_d = glpf_pkg::ST_IDLE;
				end
			end
			glpf_pkg::ST_EMIT_UP: begin
				cmd.emit_up = 1'b1;
				if (stat.out_free) begin
					state_d = stat.last_px_q ? glpf_pkg::ST_SCAN : glpf_pkg::ST_IDLE;
				end
			end
			glpf_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_adv && stat.scan_last) begin
					state_d = glpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = glpf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/glpf_datapath.sv]
// Datapath: row store, neighbour window, compares, last-row flags and output register
module glpf_datapath #(
	parameter int MAX_COLS = glpf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = glpf_pkg::MAX_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  glpf_pkg::glpf_cmd_t                  cmd,
	output glpf_pkg::glpf_stat_t                 stat,
	input  logic                                 cfg_we,
	input  logic [glpf_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [glpf_pkg::DIM_W-1:0]           cfg_wdata,
	input  logic signed [glpf_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [glpf_pkg::POS_W-1:0]           peak_row,
	output logic [glpf_pkg::POS_W-1:0]           peak_col,
	output logic                                 frame_end
);

	localparam int RMAX  = (MAX_ROWS > 63) ? 63 : MAX_ROWS;
	localparam int ROW_W = (RMAX > 1) ? $clog2(RMAX) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = 3 * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = glpf_pkg::SAMPLE_W;
	localparam int DW    = glpf_pkg::DIM_W;
	localparam int PW    = glpf_pkg::POS_W;
	localparam logic [DW-1:0] RMAX_D = DW'(RMAX);
	localparam logic [DW-1:0] CMAX_D = DW'(MAX_COLS);

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
		input logic [DW-1:0] maxv);
		if (v == '0) begin
			return DW'(1);
		end else if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [1:0] bank,
		input logic [COL_W-1:0] col);
		return AW'(AW'(bank) * AW'(MAX_COLS)) + AW'(col);
	endfunction

	// Configuration and position state
	logic [DW-1:0]       rows_q, cols_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [1:0]          bank_q;
	logic [MAX_COLS-1:0] flags_q;
	logic [COL_W-1:0]    k_q;
	logic                last_px_q;

	// Row store and window
	logic signed [SW-1:0] mem [DEPTH];
	logic signed [SW-1:0] rd_a_q, rd_b_q;
	logic signed [SW-1:0] v_q;
	logic signed [SW-1:0] p1_l_q, p1_c_q;
	logic signed [SW-1:0] cur_l1_q, cur_l2_q;

	// Pending result of the pixel above
	logic [PW-1:0] up_row_q, up_col_q, scan_row_q;

	// Output register
	logic          out_valid_q;
	logic [PW-1:0] out_row_q, out_col_q;
	logic          out_end_q;

	logic [DW-1:0]       rows_eff, cols_eff;
	logic                last_row, last_col;
	logic                has_up, has_up2, has_left, has_left2, has_right;
	logic [1:0]          bank_prev, bank_prev2;
	logic [COL_W-1:0]    col_a;
	logic [AW-1:0]       rd_a_addr;
	logic                rd_a_en;
	logic                pk_up, lr_flag, end_flag;
	logic                out_free, scan_hit, scan_adv, scan_last, scan_more;
	logic                push_up, push_scan;
	logic [MAX_COLS-1:0] flag_set;

	assign rows_eff = clamp_dim(rows_q, RMAX_D);
	assign cols_eff = clamp_dim(cols_q, CMAX_D);

	// Border conditions of the current position
	assign last_row  = DW'(row_q) == rows_eff - DW'(1);
	assign last_col  = DW'(col_q) == cols_eff - DW'(1);
	assign has_up    = row_q != '0;
	assign has_up2   = DW'(row_q) >= DW'(2);
	assign has_left  = col_q != '0;
	assign has_left2 = DW'(col_q) >= DW'(2);
	assign has_right = !last_col;

	assign bank_prev  = (bank_q == 2'd0) ? 2'd2 : bank_q - 2'd1;
	assign bank_prev2 = (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;

	// Port A fetches the previous row one column ahead; at column 0 it takes
	// column 0 on transfer and column 1 on the fetch cycle
	always_comb begin
		if (cmd.fetch) begin
			col_a = has_right ? COL_W'(1) : '0;
		end else if (col_q == '0) begin
			col_a = '0;
		end else begin
			col_a = has_right ? col_q + COL_W'(1) : col_q;
		end
	end
	assign rd_a_addr = slot(bank_prev, col_a);
	assign rd_a_en   = cmd.accept | cmd.fetch;

	// Row store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[slot(bank_q, col_q)] <= sample;
			rd_b_q <= mem[slot(bank_prev2, col_q)];
		end
		if (rd_a_en) begin
			rd_a_q <= mem[rd_a_addr];
		end
	end

	// Decision for the pixel above the new one
	assign pk_up = has_up && (p1_c_q >= v_q)
		&& !(has_up2 && (p1_c_q < rd_b_q))
		&& !(has_left && (p1_c_q < p1_l_q))
		&& !(has_right && (p1_c_q < rd_a_q));

	// Last row: left neighbour of the new pixel, and the new pixel at row end
	assign lr_flag = has_left && (cur_l1_q >= v_q)
		&& !(has_left2 && (cur_l1_q < cur_l2_q))
		&& !(has_up && (cur_l1_q < p1_l_q));
	assign end_flag = !(has_left && (v_q < cur_l1_q)) && !(has_up && (v_q < p1_c_q));

	// Last-row flags raised by the current compare step
	always_comb begin
		flag_set = '0;
		if (last_row && lr_flag) begin
			flag_set[col_q - COL_W'(1)] = 1'b1;
		end
		if (last_row && last_col && end_flag) begin
			flag_set[col_q] = 1'b1;
		end
	end

	// Scan over the last-row flags
	assign out_free  = !out_valid_q || out_ready;
	assign scan_hit  = flags_q[k_q];
	assign scan_adv  = !scan_hit || out_free;
	assign scan_last = DW'(k_q) == cols_eff - DW'(1);
	assign scan_more = |((flags_q >> k_q) >> 1);
	assign push_up   = cmd.emit_up && out_free;
	assign push_scan = cmd.scan && scan_hit && out_free;

	// Window registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= sample;
		end
		if (cmd.fetch) begin
			p1_c_q <= rd_a_q;
		end
		if (cmd.calc) begin
			p1_l_q     <= p1_c_q;
			p1_c_q     <= rd_a_q;
			cur_l2_q   <= cur_l1_q;
			cur_l1_q   <= v_q;
			up_row_q   <= PW'(row_q - ROW_W'(1));
			up_col_q   <= PW'(col_q);
			scan_row_q <= PW'(row_q);
		end
	end

	// Configuration, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= glpf_pkg::DIM_RESET;
			cols_q    <= glpf_pkg::DIM_RESET;
			row_q     <= '0;
			col_q     <= '0;
			bank_q    <= '0;
			flags_q   <= '0;
			k_q       <= '0;
			last_px_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				glpf_pkg::REG_FRAME_ROWS: rows_q <= cfg_wdata;
				glpf_pkg::REG_FRAME_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
			row_q   <= '0;
			col_q   <= '0;
			bank_q  <= '0;
			flags_q <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.calc) begin
				last_px_q <= last_row && last_col;
				flags_q   <= flags_q | flag_set;
				if (last_row && last_col) begin
					row_q  <= '0;
					col_q  <= '0;
					bank_q <= '0;
				end else if (last_col) begin
					row_q  <= row_q + ROW_W'(1);
					col_q  <= '0;
					bank_q <= (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (cmd.scan && scan_adv) begin
				if (scan_last) begin
					k_q     <= '0;
					flags_q <= '0;
				end else begin
					k_q <= k_q + COL_W'(1);
				end
			end
		end
	end

	// Output register: takes a result whenever the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_up || push_scan) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_up) begin
			out_row_q <= up_row_q;
			out_col_q <= up_col_q;
			out_end_q <= last_px_q && (flags_q == '0);
		end else if (push_scan) begin
			out_row_q <= scan_row_q;
			out_col_q <= PW'(k_q);
			out_end_q <= !scan_more;
		end
	end

	assign out_valid = out_valid_q;
	assign peak_row  = out_row_q;
	assign peak_col  = out_col_q;
	assign frame_end = out_end_q;

	assign stat.first_col = col_q == '0;
	assign stat.pk_up     = pk_up;
	assign stat.last_px   = last_row && last_col;
	assign stat.last_px_q = last_px_q;
	assign stat.out_free  = out_free;
	assign stat.scan_adv  = scan_adv;
	assign stat.scan_last = scan_last;

endmodule

[hdl/grid_local_peak_finder.sv]
// Top level of the grid local peak finder
//
//  channel    dir   transfer moves                    notes
//  sample_ch  in    one signed sample, raster order   ready only between items
//  peak_ch    out   row, column, frame end flag       registered, stall safe
//  cfg_ch     in    register index, 6-bit value       always ready, restarts frame
//
// An item takes a transfer and a compare step, and at column 0 a fetch step
// between them where the first sample of the row above is read ahead; the row
// store has two read ports. A peak decided for the row above adds an emit step;
// the final pixel adds a scan over the last-row flags, column by column.
// A stalled result holds the scan or emit step; a new sample is taken while
// the last result still waits. Reset returns to 20 x 20 and frame start.
module grid_local_peak_finder #(
	parameter int MAX_COLS = glpf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = glpf_pkg::MAX_ROWS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	glpf_sample_if.sink sample_ch,
	glpf_peak_if.source peak_ch,
	glpf_cfg_if.sink    cfg_ch
);

	glpf_pkg::glpf_cmd_t  cmd;
	glpf_pkg::glpf_stat_t stat;

	assign cfg_ch.ready = 1'b1;

	glpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	glpf_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_ch.valid),
		.cfg_idx   (cfg_ch.idx),
		.cfg_wdata (cfg_ch.wdata),
		.sample    (sample_ch.sample),
		.out_valid (peak_ch.valid),
		.out_ready (peak_ch.ready),
		.peak_row  (peak_ch.peak_row),
		.peak_col  (peak_ch.peak_col),
		.frame_end (peak_ch.frame_end)
	);

endmodule

[hdl/glpf_checker.sv]
// Port checker of the grid local peak finder and its binding
`include "grid_local_peak_finder_macros.svh"

module glpf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [glpf_pkg::POS_W-1:0]   out_row,
	input logic [glpf_pkg::POS_W-1:0]   out_col,
	input logic                         out_end
);

	// A sample transfer starts work, so the next cycle takes no sample
	`GLPF_ASSERT(a_busy_after_in, clk, arst_n, in_valid && in_ready |=> !in_ready)

	// No result is offered right out of reset
	`GLPF_ASSERT_NR(a_reset_quiet, clk, !arst_n |=> !out_valid)

	// A stalled result stays offered
	`GLPF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// A stalled result keeps its payload
	`GLPF_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(out_end))

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (peak_ch.valid),
	.out_ready (peak_ch.ready),
	.out_row   (peak_ch.peak_row),
	.out_col   (peak_ch.peak_col),
	.out_end   (peak_ch.frame_end)
);
